[sv/svmab_pkg.sv]
package svmab_pkg;

   localparam int AXES        = 6;
   localparam int SAMPLE_W    = 16;
   localparam int GYRO_BASE   = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_BIAS_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_BIAS_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GYRO_BIAS_Z = 2'd2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

[sv/svmab_if.sv]
interface svmab_req_if;
   logic                    valid;
   logic                    ready;
   logic                    data_ready;
   svmab_pkg::sample_type   accel_x;
   svmab_pkg::sample_type   accel_y;
   svmab_pkg::sample_type   accel_z;
   svmab_pkg::sample_type   gyro_x;
   svmab_pkg::sample_type   gyro_y;
   svmab_pkg::sample_type   gyro_z;

   modport source (
      output valid, data_ready, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
      input  ready
   );
   modport sink (
      input  valid, data_ready, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
      output ready
   );
endinterface

interface svmab_rsp_if;
   logic                    valid;
   logic                    ready;
   svmab_pkg::sample_type   filtered_accel_x;
   svmab_pkg::sample_type   filtered_accel_y;
   svmab_pkg::sample_type   filtered_accel_z;
   svmab_pkg::sample_type   filtered_gyro_x;
   svmab_pkg::sample_type   filtered_gyro_y;
   svmab_pkg::sample_type   filtered_gyro_z;

   modport source (
      output valid, filtered_accel_x, filtered_accel_y, filtered_accel_z,
             filtered_gyro_x, filtered_gyro_y, filtered_gyro_z,
      input  ready
   );
   modport sink (
      input  valid, filtered_accel_x, filtered_accel_y, filtered_accel_z,
             filtered_gyro_x, filtered_gyro_y, filtered_gyro_z,
      output ready
   );
endinterface

[sv/six_axis_moving_average_bias.sv]
// Throughput: one item per cycle unless rsp.ready stalls the output; the front
// keeps a running window sum per axis and the back divides through one
// reciprocal multiplier stage per axis, registered in s1 and then out_ff.
// A two-entry queue between front and back lets either side stall alone.
// Reset (synchronous): windows, sums, averages and gyro biases clear to zero.
module six_axis_moving_average_bias #(
   parameter int WINDOW_LENGTH = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   svmab_req_if.sink                             req,
   svmab_rsp_if.source                           rsp,
   input  logic                                  csr_we,
   input  logic [svmab_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [svmab_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SUM_W   = svmab_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int ENTRY_W = svmab_pkg::AXES * SUM_W + 1;

   logic                push_valid, push_ready;
   logic [ENTRY_W-1:0]  push_data;
   logic                pop_valid, pop_ready;
   logic [ENTRY_W-1:0]  pop_data;

   svmab_front #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .SUM_W         (SUM_W),
      .ENTRY_W       (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   svmab_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   svmab_back #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .SUM_W         (SUM_W),
      .ENTRY_W       (ENTRY_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (rsp)
   );

endmodule

[sv/svmab_front.sv]
module svmab_front #(
   parameter int WINDOW_LENGTH = 10,
   parameter int SUM_W         = 20,
   parameter int ENTRY_W       = 121
) (
   input  logic                clock,
   input  logic                reset,
   svmab_req_if.sink           req,
   output logic                push_valid,
   input  logic                push_ready,
   output logic [ENTRY_W-1:0]  push_data
);

   localparam int EXT_W = SUM_W - svmab_pkg::SAMPLE_W;

   svmab_pkg::sample_type  window_ff [svmab_pkg::AXES][WINDOW_LENGTH];
   logic [SUM_W-1:0]       sum_ff    [svmab_pkg::AXES];
   logic [SUM_W-1:0]       sum_in    [svmab_pkg::AXES];
   svmab_pkg::sample_type  sample    [svmab_pkg::AXES];
   logic                   accept;

   assign sample[0] = req.accel_x;
   assign sample[1] = req.accel_y;
   assign sample[2] = req.accel_z;
   assign sample[3] = req.gyro_x;
   assign sample[4] = req.gyro_y;
   assign sample[5] = req.gyro_z;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;

   // running sum: add newest, drop oldest
   always_comb begin
      for (int a = 0; a < svmab_pkg::AXES; a++) begin
         sum_in[a] = sum_ff[a]
                   + {{EXT_W{sample[a][svmab_pkg::SAMPLE_W-1]}}, sample[a]}
                   - {{EXT_W{window_ff[a][0][svmab_pkg::SAMPLE_W-1]}}, window_ff[a][0]};
      end
   end

   always_comb begin
      push_data[ENTRY_W-1] = req.data_ready;
      for (int a = 0; a < svmab_pkg::AXES; a++) begin
         push_data[a*SUM_W +: SUM_W] = req.data_ready ? sum_in[a] : sum_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < svmab_pkg::AXES; a++) begin
            sum_ff[a] <= '0;
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
               window_ff[a][k] <= '0;
            end
         end
      end else if (accept && req.data_ready) begin
         for (int a = 0; a < svmab_pkg::AXES; a++) begin
            sum_ff[a] <= sum_in[a];
            for (int k = 0; k < WINDOW_LENGTH - 1; k++) begin
               window_ff[a][k] <= window_ff[a][k+1];
            end
            window_ff[a][WINDOW_LENGTH-1] <= sample[a];
         end
      end
   end

endmodule

[sv/svmab_queue.sv]
module svmab_queue #(
   parameter int DATA_W = 121
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  logic [DATA_W-1:0]  push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output logic [DATA_W-1:0]  pop_data
);

   localparam int DEPTH = svmab_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/svmab_back.sv]
module svmab_back #(
   parameter int WINDOW_LENGTH = 10,
   parameter int SUM_W         = 20,
   parameter int ENTRY_W       = 121
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  logic [ENTRY_W-1:0]                    pop_data,
   input  logic                                  csr_we,
   input  logic [svmab_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [svmab_pkg::CSR_DATA_W-1:0]      csr_wdata,
   svmab_rsp_if.source                           rsp
);

   localparam int SW      = svmab_pkg::SAMPLE_W;
   localparam int SHIFT   = SUM_W + $clog2(WINDOW_LENGTH);
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << SHIFT) + longint'(WINDOW_LENGTH) - 1) / longint'(WINDOW_LENGTH);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

   logic                   en;
   logic                   s1_valid_ff;
   logic                   s1_flag_ff;
   logic                   s1_neg_ff  [svmab_pkg::AXES];
   logic [PROD_W-1:0]      s1_prod_ff [svmab_pkg::AXES];
   logic [PROD_W-1:0]      prod_in    [svmab_pkg::AXES];
   logic                   neg_in     [svmab_pkg::AXES];
   logic [SUM_W-1:0]       sum        [svmab_pkg::AXES];
   logic [SUM_W-1:0]       mag        [svmab_pkg::AXES];
   logic [SW-1:0]          quot       [svmab_pkg::AXES];
   logic [SW-1:0]          sel        [svmab_pkg::AXES];
   logic [SW-1:0]          filt_in    [svmab_pkg::AXES];
   logic [SW-1:0]          avg_ff     [svmab_pkg::AXES];
   logic [SW-1:0]          out_ff     [svmab_pkg::AXES];
   logic [SW-1:0]          bias_ff    [3];
   logic                   out_valid_ff;

   assign en        = !out_valid_ff || rsp.ready;
   assign pop_ready = en;

   // magnitude times reciprocal gives the exact truncated quotient
   always_comb begin
      for (int a = 0; a < svmab_pkg::AXES; a++) begin
         sum[a]     = pop_data[a*SUM_W +: SUM_W];
         neg_in[a]  = sum[a][SUM_W-1];
         mag[a]     = neg_in[a] ? SUM_W'(-sum[a]) : sum[a];
         prod_in[a] = mag[a] * RECIP;
      end
   end

   always_comb begin
      for (int a = 0; a < svmab_pkg::AXES; a++) begin
         quot[a] = s1_neg_ff[a] ? SW'(-s1_prod_ff[a][SHIFT +: SW])
                                : s1_prod_ff[a][SHIFT +: SW];
         sel[a]  = s1_flag_ff ? quot[a] : avg_ff[a];
      end
      for (int a = 0; a < svmab_pkg::GYRO_BASE; a++) begin
         filt_in[a] = sel[a];
      end
      filt_in[svmab_pkg::GYRO_BASE]     = sel[svmab_pkg::GYRO_BASE]     - bias_ff[0];
      filt_in[svmab_pkg::GYRO_BASE + 1] = sel[svmab_pkg::GYRO_BASE + 1] - bias_ff[1];
      filt_in[svmab_pkg::GYRO_BASE + 2] = sel[svmab_pkg::GYRO_BASE + 2] - bias_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < 3; g++) begin
            bias_ff[g] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            svmab_pkg::CSR_GYRO_BIAS_X: bias_ff[0] <= csr_wdata;
            svmab_pkg::CSR_GYRO_BIAS_Y: bias_ff[1] <= csr_wdata;
            svmab_pkg::CSR_GYRO_BIAS_Z: bias_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int a = 0; a < svmab_pkg::AXES; a++) begin
            avg_ff[a] <= '0;
         end
      end else if (en) begin
         s1_valid_ff  <= pop_valid;
         out_valid_ff <= s1_valid_ff;
         if (s1_valid_ff && s1_flag_ff) begin
            for (int a = 0; a < svmab_pkg::AXES; a++) begin
               avg_ff[a] <= quot[a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_flag_ff <= pop_data[ENTRY_W-1];
         for (int a = 0; a < svmab_pkg::AXES; a++) begin
            s1_neg_ff[a]  <= neg_in[a];
            s1_prod_ff[a] <= prod_in[a];
            out_ff[a]     <= filt_in[a];
         end
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.filtered_accel_x = out_ff[0];
   assign rsp.filtered_accel_y = out_ff[1];
   assign rsp.filtered_accel_z = out_ff[2];
   assign rsp.filtered_gyro_x  = out_ff[3];
   assign rsp.filtered_gyro_y  = out_ff[4];
   assign rsp.filtered_gyro_z  = out_ff[5];

endmodule

[verif/svmab_checker.sv]
module svmab_checker #(
   parameter int WINDOW_TAPS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   svmab_req_if                              req,
   svmab_rsp_if                              rsp,
   input  logic                              csr_we,
   input  logic [svmab_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [svmab_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                mismatches,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      svmab_pkg::sample_type axis [svmab_pkg::AXES];
   } filtered_type;

   svmab_pkg::sample_type window [svmab_pkg::AXES][WINDOW_TAPS];
   svmab_pkg::sample_type average [svmab_pkg::AXES];
   svmab_pkg::sample_type gyro_bias [svmab_pkg::AXES-svmab_pkg::GYRO_BASE];
   filtered_type          expected_filtered [$];

   string axis_name [svmab_pkg::AXES] = '{
      "filtered_accel_x", "filtered_accel_y", "filtered_accel_z",
      "filtered_gyro_x", "filtered_gyro_y", "filtered_gyro_z"
   };

   function automatic filtered_type advance_window(
      input logic                  flag,
      input svmab_pkg::sample_type raw [svmab_pkg::AXES]
   );
      int           sum;
      filtered_type result;
      if (flag) begin
         for (int a = 0; a < svmab_pkg::AXES; a++) begin
            for (int k = 1; k < WINDOW_TAPS; k++) begin
               window[a][k-1] = window[a][k];
            end
            window[a][WINDOW_TAPS-1] = raw[a];
            sum = 0;
            for (int k = 0; k < WINDOW_TAPS; k++) begin
               sum += int'(window[a][k]);
            end
            average[a] = svmab_pkg::sample_type'(sum / WINDOW_TAPS);
         end
      end
      for (int a = 0; a < svmab_pkg::AXES; a++) begin
         if (a < svmab_pkg::GYRO_BASE) begin
            result.axis[a] = average[a];
         end else begin
            result.axis[a] = svmab_pkg::sample_type'(
               average[a] - gyro_bias[a-svmab_pkg::GYRO_BASE]);
         end
      end
      return result;
   endfunction

   always @(posedge clock) begin
      filtered_type          seen;
      filtered_type          want;
      svmab_pkg::sample_type raw [svmab_pkg::AXES];
      if (reset) begin
         foreach (window[a, k]) window[a][k] = '0;
         foreach (average[a]) average[a] = '0;
         foreach (gyro_bias[g]) gyro_bias[g] = '0;
         expected_filtered.delete();
         mismatches = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            seen.axis[0] = rsp.filtered_accel_x;
            seen.axis[1] = rsp.filtered_accel_y;
            seen.axis[2] = rsp.filtered_accel_z;
            seen.axis[3] = rsp.filtered_gyro_x;
            seen.axis[4] = rsp.filtered_gyro_y;
            seen.axis[5] = rsp.filtered_gyro_z;
            if (expected_filtered.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("%t checker: result with no item waiting", $realtime);
               end
               mismatches++;
            end else begin
               want = expected_filtered.pop_front();
               for (int a = 0; a < svmab_pkg::AXES; a++) begin
                  if (seen.axis[a] !== want.axis[a]) begin
                     if (mismatches < REPORT_LIMIT) begin
                        $display("%t checker: %s expected %0d got %0d", $realtime,
                                 axis_name[a], want.axis[a], seen.axis[a]);
                     end
                     mismatches++;
                  end
               end
            end
         end
         if (req.valid && req.ready) begin
            raw[0] = req.accel_x;
            raw[1] = req.accel_y;
            raw[2] = req.accel_z;
            raw[3] = req.gyro_x;
            raw[4] = req.gyro_y;
            raw[5] = req.gyro_z;
            expected_filtered.push_back(advance_window(req.data_ready, raw));
         end
         if (csr_we) begin
            case (csr_index)
               svmab_pkg::CSR_GYRO_BIAS_X:
                  gyro_bias[0] = svmab_pkg::sample_type'(csr_wdata);
               svmab_pkg::CSR_GYRO_BIAS_Y:
                  gyro_bias[1] = svmab_pkg::sample_type'(csr_wdata);
               svmab_pkg::CSR_GYRO_BIAS_Z:
                  gyro_bias[2] = svmab_pkg::sample_type'(csr_wdata);
               default: ;
            endcase
         end
      end
      pending = expected_filtered.size();
   end

endmodule

[verif/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_TAPS  = 10;
   localparam int IDLE_PERCENT = 35;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 200;
   localparam int TAIL_CYCLES  = 10;
   localparam logic [svmab_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [svmab_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [svmab_pkg::CSR_DATA_W-1:0]  csr_wdata;
   bit                                steady;
   int                                quiet_cycles;
   int                                mismatches;
   int                                pending;

   svmab_req_if req_if ();
   svmab_rsp_if rsp_if ();

   six_axis_moving_average_bias #(
      .WINDOW_LENGTH(WINDOW_TAPS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   svmab_checker #(
      .WINDOW_TAPS(WINDOW_TAPS)
   ) filter_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic svmab_pkg::sample_type random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return svmab_pkg::sample_type'($urandom);
      if (pick < 85) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      return svmab_pkg::sample_type'($urandom_range(40) - 20);
   endfunction

   task automatic send_item(input logic flag,
                            input svmab_pkg::sample_type raw [svmab_pkg::AXES]);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.data_ready <= flag;
      req_if.accel_x    <= raw[0];
      req_if.accel_y    <= raw[1];
      req_if.accel_z    <= raw[2];
      req_if.gyro_x     <= raw[3];
      req_if.gyro_y     <= raw[4];
      req_if.gyro_z     <= raw[5];
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_random(input logic flag);
      svmab_pkg::sample_type raw [svmab_pkg::AXES];
      foreach (raw[a]) raw[a] = random_sample();
      send_item(flag, raw);
   endtask

   task automatic send_uniform(input svmab_pkg::sample_type value);
      svmab_pkg::sample_type raw [svmab_pkg::AXES];
      foreach (raw[a]) raw[a] = value;
      send_item(1'b1, raw);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [svmab_pkg::CSR_INDEX_W-1:0] index,
                            input logic [svmab_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   task automatic load_biases(input logic [svmab_pkg::CSR_DATA_W-1:0] bias_x,
                              input logic [svmab_pkg::CSR_DATA_W-1:0] bias_y,
                              input logic [svmab_pkg::CSR_DATA_W-1:0] bias_z);
      write_csr(svmab_pkg::CSR_GYRO_BIAS_X, bias_x);
      write_csr(svmab_pkg::CSR_GYRO_BIAS_Y, bias_y);
      write_csr(CSR_UNUSED, svmab_pkg::CSR_DATA_W'($urandom));
      write_csr(svmab_pkg::CSR_GYRO_BIAS_Z, bias_z);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      steady            = 1'b0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.data_ready = 1'b0;
      req_if.accel_x    = '0;
      req_if.accel_y    = '0;
      req_if.accel_z    = '0;
      req_if.gyro_x     = '0;
      req_if.gyro_y     = '0;
      req_if.gyro_z     = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // flag clear right after reset: averages still zero, raw fields ignored
      send_random(1'b0);
      repeat (WINDOW_TAPS) send_uniform(16'sh7fff);
      send_random(1'b0);
      repeat (WINDOW_TAPS) send_uniform(16'sh8000);
      drain();

      // gyro wrap on repeat of stored averages, then negative truncation
      load_biases(16'h7fff, 16'h8000, 16'h0001);
      send_random(1'b0);
      send_uniform(16'sh0001);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            1: load_biases(16'h0000, 16'h0000, 16'h0000);
            2: load_biases(16'h7fff, 16'h7fff, 16'h7fff);
            3: load_biases(16'h8000, 16'h8000, 16'h8000);
            default: load_biases(svmab_pkg::CSR_DATA_W'($urandom),
                                 svmab_pkg::CSR_DATA_W'($urandom),
                                 svmab_pkg::CSR_DATA_W'($urandom));
         endcase
         steady = (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == PHASE_ITEMS / 2) drain();
            send_random($urandom_range(99) < 80);
         end
      end
      steady = 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
